// ===== hw/rtl/sest_pkg.sv =====
`default_nettype none

package sest_pkg;

    // geometry defaults and fixed field width
    localparam int unsigned ROWS_DEF = 512;
    localparam int unsigned COLS_DEF = 512;
    localparam int unsigned FIELD_W  = 9;

    // operation codes on the request channel
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // command classes handed from front to back
    typedef enum logic [1:0] {
        CMD_ZERO,
        CMD_CLEAR,
        CMD_EDGE,
        CMD_READ
    } t_cmd_kind;

    // classified command, endpoints already ordered by row
    typedef struct packed {
        t_cmd_kind            kind;
        logic [FIELD_W-1:0]   row;      // first row of an edge, or the row read
        logic [FIELD_W-1:0]   y_high;   // walk stops before this row
        logic [FIELD_W-1:0]   x_low;
        logic [FIELD_W-1:0]   dx_mag;
        logic                 dx_neg;
        logic [FIELD_W-1:0]   dy;
    } t_cmd;

    // divider result toward the back end
    typedef struct packed {
        logic                 done;
        logic [FIELD_W-1:0]   quo;
        logic [FIELD_W-1:0]   rem;
    } t_div_res;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_DIV,
        BK_WALK,
        BK_READ,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/sest_if.sv =====
`default_nettype none

// request channel
interface sest_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [8:0] x_start;
    logic [8:0] y_start;
    logic [8:0] x_end;
    logic [8:0] y_end;
    logic [8:0] row;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end, row,
        input  ready
    );
    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end, row,
        output ready
    );
endinterface

// result channel
interface sest_rsp_if;
    logic       valid;
    logic       ready;
    logic [8:0] span_left;
    logic [8:0] span_right;
    logic       span_valid;

    modport source (
        output valid, span_left, span_right, span_valid,
        input  ready
    );
    modport sink (
        input  valid, span_left, span_right, span_valid,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sest_front.sv =====
`default_nettype none

module sest_front #(
    parameter int unsigned ROWS = sest_pkg::ROWS_DEF
) (
    sest_req_if.sink      i_req,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output sest_pkg::t_cmd o_cmd
);

    logic                           swap;
    logic [sest_pkg::FIELD_W-1:0]   xl;
    logic [sest_pkg::FIELD_W-1:0]   xh;
    logic [sest_pkg::FIELD_W-1:0]   yl;
    logic [sest_pkg::FIELD_W-1:0]   yh;
    logic [sest_pkg::FIELD_W-1:0]   dy;
    logic                           neg;

    // handshake passes straight to the queue
    assign o_push_valid = i_req.valid;
    assign i_req.ready  = i_push_ready;

    // order endpoints by row
    assign swap = (i_req.y_end < i_req.y_start);
    assign xl   = swap ? i_req.x_end   : i_req.x_start;
    assign yl   = swap ? i_req.y_end   : i_req.y_start;
    assign xh   = swap ? i_req.x_start : i_req.x_end;
    assign yh   = swap ? i_req.y_start : i_req.y_end;
    assign dy   = yh - yl;
    assign neg  = (xh < xl);

    // classify the beat
    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = sest_pkg::CMD_ZERO;
        o_cmd.x_low  = xl;
        o_cmd.y_high = yh;
        o_cmd.dy     = dy;
        o_cmd.dx_neg = neg;
        o_cmd.dx_mag = neg ? (xl - xh) : (xh - xl);
        o_cmd.row    = yl;
        unique case (i_req.operation)
            sest_pkg::OP_CLEAR: begin
                o_cmd.kind = sest_pkg::CMD_CLEAR;
            end
            sest_pkg::OP_ADD: begin
                // a horizontal edge touches nothing
                o_cmd.kind = (dy == '0) ? sest_pkg::CMD_ZERO : sest_pkg::CMD_EDGE;
            end
            sest_pkg::OP_READ: begin
                o_cmd.row  = i_req.row;
                o_cmd.kind = (32'(i_req.row) < ROWS) ? sest_pkg::CMD_READ
                                                     : sest_pkg::CMD_ZERO;
            end
            default: begin
                o_cmd.kind = sest_pkg::CMD_ZERO;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sest_fifo.sv =====
`default_nettype none

module sest_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire sest_pkg::t_cmd  i_push_cmd,
    output logic                 o_pop_valid,
    input  wire logic            i_pop,
    output sest_pkg::t_cmd       o_pop_cmd
);

    sest_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           n_wr_ptr;
    logic           r_rd_ptr;
    logic           n_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sest_div.sv =====
`default_nettype none

module sest_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sest_pkg::FIELD_W-1:0]  i_dividend,
    input  wire logic [sest_pkg::FIELD_W-1:0]  i_divisor,
    output sest_pkg::t_div_res                 o_res
);

    localparam int unsigned W  = sest_pkg::FIELD_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  n_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  r_dvs;
    logic [W-1:0]  n_dvs;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_done;
    logic          n_done;
    logic [W:0]    shifted;
    logic          fits;

    // one quotient bit per cycle, restoring
    assign shifted = {r_rem, r_quo[W-1]};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
            n_cnt = CW'(W);
        end else if (r_cnt != '0) begin
            n_rem  = fits ? W'(shifted - {1'b0, r_dvs}) : shifted[W-1:0];
            n_quo  = {r_quo[W-2:0], fits};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/sest_back.sv =====
`default_nettype none

module sest_back #(
    parameter int unsigned ROWS = sest_pkg::ROWS_DEF,
    parameter int unsigned COLS = sest_pkg::COLS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire sest_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    sest_rsp_if.source          o_rsp
);

    localparam int unsigned W  = sest_pkg::FIELD_W;
    localparam int unsigned RW = $clog2(ROWS);
    localparam int unsigned CW = $clog2(COLS);
    localparam logic [CW-1:0] COL_MAX = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    // edge stores
    logic [CW-1:0] mem_l [ROWS];
    logic [CW-1:0] mem_r [ROWS];

    sest_pkg::t_back_state r_state;
    sest_pkg::t_back_state n_state;
    sest_pkg::t_cmd        r_cmd;
    sest_pkg::t_cmd        n_cmd;
    sest_pkg::t_div_res    div_res;

    logic [RW-1:0] r_sweep;
    logic [RW-1:0] n_sweep;
    logic [W-1:0]  r_row;
    logic [W-1:0]  n_row;
    logic [W-1:0]  r_q;
    logic [W-1:0]  n_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  r_q0;
    logic [W-1:0]  n_q0;
    logic [W-1:0]  r_r0;
    logic [W-1:0]  n_r0;
    logic          r_s1_v;
    logic          n_s1_v;
    logic [RW-1:0] r_s1_addr;
    logic [RW-1:0] n_s1_addr;
    logic [CW-1:0] r_s1_x;
    logic [CW-1:0] n_s1_x;
    logic [W-1:0]  r_res_l;
    logic [W-1:0]  n_res_l;
    logic [W-1:0]  r_res_r;
    logic [W-1:0]  n_res_r;
    logic          r_res_v;
    logic          n_res_v;
    logic          r_ov;
    logic          n_ov;
    logic [W-1:0]  r_o_l;
    logic [W-1:0]  n_o_l;
    logic [W-1:0]  r_o_r;
    logic [W-1:0]  n_o_r;
    logic          r_o_v;
    logic          n_o_v;
    logic [CW-1:0] r_rd_l;
    logic [CW-1:0] r_rd_r;

    logic          div_start;
    logic [RW-1:0] rd_addr;
    logic          we;
    logic [RW-1:0] wa;
    logic [CW-1:0] wd_l;
    logic [CW-1:0] wd_r;
    logic [W:0]    rem_sum;
    logic          rem_wrap;
    logic [W:0]    x_wide;
    logic [W-1:0]  x_col;
    logic [CW-1:0] x_sat;
    logic          walk_go;

    sest_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.dx_mag),
        .i_divisor  (i_cmd.dy),
        .o_res      (div_res)
    );

    // column of the current row: quotient and remainder stepped per row
    assign rem_sum  = {1'b0, r_rem} + {1'b0, r_r0};
    assign rem_wrap = (rem_sum >= {1'b0, r_cmd.dy});
    assign x_wide   = r_cmd.dx_neg ? ({1'b0, r_cmd.x_low} - {1'b0, r_q})
                                   : ({1'b0, r_cmd.x_low} + {1'b0, r_q});
    assign x_col    = x_wide[W-1:0];
    assign x_sat    = (32'(x_col) > (COLS - 1)) ? COL_MAX : CW'(x_col);
    assign walk_go  = (r_row < r_cmd.y_high) && (32'(r_row) < ROWS);

    // write port: clearing sweep or min/max update of the walk
    always_comb begin
        we   = 1'b0;
        wa   = r_s1_addr;
        wd_l = (r_s1_x < r_rd_l) ? r_s1_x : r_rd_l;
        wd_r = (r_s1_x > r_rd_r) ? r_s1_x : r_rd_r;
        if (r_state == sest_pkg::BK_INIT || r_state == sest_pkg::BK_CLEAR) begin
            we   = 1'b1;
            wa   = r_sweep;
            wd_l = COL_MAX;
            wd_r = '0;
        end else if (r_s1_v) begin
            we = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_sweep   = r_sweep;
        n_row     = r_row;
        n_q       = r_q;
        n_rem     = r_rem;
        n_q0      = r_q0;
        n_r0      = r_r0;
        n_s1_v    = 1'b0;
        n_s1_addr = r_s1_addr;
        n_s1_x    = r_s1_x;
        n_res_l   = r_res_l;
        n_res_r   = r_res_r;
        n_res_v   = r_res_v;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        rd_addr   = RW'(r_row);
        unique case (r_state)
            sest_pkg::BK_INIT,
            sest_pkg::BK_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ROW_LAST) begin
                    n_sweep = '0;
                    n_state = (r_state == sest_pkg::BK_INIT) ? sest_pkg::BK_IDLE
                                                             : sest_pkg::BK_EMIT;
                end
            end
            sest_pkg::BK_IDLE: begin
                rd_addr = RW'(i_cmd.row);
                n_res_l = '0;
                n_res_r = '0;
                n_res_v = 1'b0;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_row     = i_cmd.row;
                    n_q       = '0;
                    n_rem     = '0;
                    n_sweep   = '0;
                    unique case (i_cmd.kind)
                        sest_pkg::CMD_CLEAR: n_state = sest_pkg::BK_CLEAR;
                        sest_pkg::CMD_EDGE: begin
                            div_start = 1'b1;
                            n_state   = sest_pkg::BK_DIV;
                        end
                        sest_pkg::CMD_READ:  n_state = sest_pkg::BK_READ;
                        default:             n_state = sest_pkg::BK_EMIT;
                    endcase
                end
            end
            sest_pkg::BK_DIV: begin
                if (div_res.done) begin
                    n_q0    = div_res.quo;
                    n_r0    = div_res.rem;
                    n_state = sest_pkg::BK_WALK;
                end
            end
            sest_pkg::BK_WALK: begin
                if (walk_go) begin
                    n_s1_v    = 1'b1;
                    n_s1_addr = RW'(r_row);
                    n_s1_x    = x_sat;
                    n_row     = r_row + 1'b1;
                    n_rem     = rem_wrap ? W'(rem_sum - {1'b0, r_cmd.dy}) : rem_sum[W-1:0];
                    n_q       = r_q + r_q0 + W'(rem_wrap);
                end else begin
                    n_state = sest_pkg::BK_EMIT;
                end
            end
            sest_pkg::BK_READ: begin
                n_res_l = W'(r_rd_l);
                n_res_r = W'(r_rd_r);
                n_res_v = (r_rd_l < r_rd_r);
                n_state = sest_pkg::BK_EMIT;
            end
            sest_pkg::BK_EMIT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = sest_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = sest_pkg::BK_IDLE;
            end
        endcase
    end

    // output register, refilled on the beat that drains it
    always_comb begin
        n_ov  = r_ov;
        n_o_l = r_o_l;
        n_o_r = r_o_r;
        n_o_v = r_o_v;
        if (r_state == sest_pkg::BK_EMIT && (!r_ov || o_rsp.ready)) begin
            n_ov  = 1'b1;
            n_o_l = r_res_l;
            n_o_r = r_res_r;
            n_o_v = r_res_v;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sest_pkg::BK_INIT;
            r_sweep <= '0;
            r_s1_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_s1_v  <= n_s1_v;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_row     <= n_row;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_q0      <= n_q0;
        r_r0      <= n_r0;
        r_s1_addr <= n_s1_addr;
        r_s1_x    <= n_s1_x;
        r_res_l   <= n_res_l;
        r_res_r   <= n_res_r;
        r_res_v   <= n_res_v;
        r_o_l     <= n_o_l;
        r_o_r     <= n_o_r;
        r_o_v     <= n_o_v;
    end

    // edge stores: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_l[wa] <= wd_l;
            mem_r[wa] <= wd_r;
        end
        r_rd_l <= mem_l[rd_addr];
        r_rd_r <= mem_r[rd_addr];
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.span_left  = r_o_l;
    assign o_rsp.span_right = r_o_r;
    assign o_rsp.span_valid = r_o_v;

endmodule

`default_nettype wire

// ===== hw/rtl/scanline_edge_span_table.sv =====
`default_nettype none

// Per-row edge table for scanline polygon fill. Each request beat gives exactly one
// result beat, in order: clear and add-edge return zeros, read returns the row's
// span [span_left, span_right) with span_valid set when left < right. A front end
// classifies requests into a two-entry queue, so requests keep being taken while a
// result waits; the back end runs one command at a time. A clear sweeps the stores
// at one row a cycle; an add-edge runs the 9-bit radix-2 divider, then walks one
// row per cycle (at most 511 rows), bound by the single write port of the stores.
// After reset the block clears the stores before the first queued request is served.
module scanline_edge_span_table #(
    parameter int unsigned ROWS = sest_pkg::ROWS_DEF,
    parameter int unsigned COLS = sest_pkg::COLS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sest_req_if.sink   i_req,
    sest_rsp_if.source o_rsp
);

    logic           push_valid;
    logic           push_ready;
    sest_pkg::t_cmd push_cmd;
    logic           pop_valid;
    logic           pop;
    sest_pkg::t_cmd pop_cmd;

    // classify requests
    sest_front #(
        .ROWS (ROWS)
    ) u_front (
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_cmd        (push_cmd)
    );

    // command queue between the two sides
    sest_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd)
    );

    // execute against the edge stores
    sest_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
